### design/bb3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 box blur unit.
// No dependencies; imported by the top level, front end, queue and back end.
package bb3_pkg;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COL_SUM_W = 10;   // three pixels
  localparam int SUM_W  = 12;      // nine pixels

  // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int Q_DEPTH = 4;
  localparam int QAW     = $clog2(Q_DEPTH);
  localparam int QCW     = $clog2(Q_DEPTH + 1);

  localparam int unsigned SIZE_RESET = 512;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_of_frame;
  } out_item_t;

  // one classified item waiting for the back end
  typedef struct packed {
    logic [SUM_W-1:0] data;      // nine-pixel sum, or center pixel on border
    logic             interior;
    logic             last;
  } bb3_entry_t;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    int unsigned r;
    r = v;
    if (v < 1) r = 1;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### design/box_blur_3x3_gray_unit.sv
`timescale 1ns / 1ps
// Top level of the 3x3 box blur: front end, item queue, back end.
// Depends on bb3_pkg, bb3_front, bb3_queue, bb3_back.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | in_item_t: action, pixel_in
//  out     | output    | out_valid / out_stall | out_item_t: pixel_out, last_of_frame
//  cfg     | input     | cfg_wr_en             | cfg_index, cfg_wdata (11 bits)
//
// One item per clock sustained while out_stall stays low; each item is read from
// the line buffer RAMs in its accept cycle, so the RAM read port sets the rate.
// An item's result passes the stage 1 registers, a queue slot and the output register.
// Reset (synchronous, rst_n low) clears counters and sets both sizes to 512, clamped to MAX_WIDTH / MAX_HEIGHT;
// the line buffers are not cleared and need no clearing pass.
// in_stall rises when the four-entry queue plus the item in flight would fill,
// so an output stall backs up into the input once the queue fills.
module box_blur_3x3_gray_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bb3_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bb3_pkg::out_item_t            out_data,
  input  logic                          cfg_wr_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata
);
  import bb3_pkg::*;

  logic           q_push, q_pop, q_head_valid;
  bb3_entry_t     q_entry, q_head;
  logic [QCW-1:0] q_count;

  bb3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  bb3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head),
    .count      (q_count)
  );

  bb3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### design/bb3_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/bb3_front.sv
`timescale 1ns / 1ps
// Front end: input handshake, size registers, raster counters, classification,
// line buffers and the column-sum window. Depends on bb3_pkg and bb3_ram.
module bb3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bb3_pkg::in_item_t                   in_data,
  input  logic                                cfg_wr_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [bb3_pkg::QCW-1:0]             q_count,
  output logic                                q_push,
  output bb3_pkg::bb3_entry_t                 q_entry
);
  import bb3_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  localparam logic [1:0] ROW_FIRST  = 2'd0;
  localparam logic [1:0] ROW_SECOND = 2'd1;
  localparam logic [1:0] ROW_LATER  = 2'd2;

  // sizes, stored already clamped
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;

  logic [XW-1:0] col_r,  col_nxt;
  logic [1:0]    rowc_r, rowc_nxt;   // input row: first, second, later
  logic [XW-1:0] ocol_r, ocol_nxt;
  logic [YW-1:0] orow_r, orow_nxt;

  logic acc, emit, interior, last, restart;

  // stage 1: line buffer data arrives, window advances
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [XW-1:0]    s1_x_r;
  logic             s1_emit_r, s1_interior_r, s1_last_r, s1_byp_r;

  logic [PIX_W-1:0]     last_mid_r, last_pix_r;
  logic [COL_SUM_W-1:0] cs_a_r, cs_b_r;

  logic [PIX_W-1:0]     rd_top, rd_mid, top, mid;
  logic [COL_SUM_W-1:0] newcol;
  logic [SUM_W-1:0]     sum;

  assign in_stall = ({1'b0, q_count} + {{QCW{1'b0}}, s1_valid_r}) >= (QCW + 1)'(Q_DEPTH);
  assign acc      = in_valid && !in_stall;

  assign emit     = (rowc_r == ROW_LATER) || ((rowc_r == ROW_SECOND) && (col_r != '0));
  assign interior = (orow_r != '0) && ((HW'(orow_r) + 1'b1) < height_r) &&
                    (ocol_r != '0) && ((WW'(ocol_r) + 1'b1) < width_r);
  assign last     = ((HW'(orow_r) + 1'b1) == height_r) && ((WW'(ocol_r) + 1'b1) == width_r);
  assign restart  = cfg_wr_en &&
                    ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  always_comb begin
    col_nxt  = col_r;
    rowc_nxt = rowc_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (restart || (acc && emit && last)) begin
      col_nxt  = '0;
      rowc_nxt = ROW_FIRST;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (acc) begin
      if ((WW'(col_r) + 1'b1) >= width_r) begin
        col_nxt = '0;
        if (rowc_r != ROW_LATER) rowc_nxt = rowc_r + 2'd1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
      if (emit) begin
        if ((WW'(ocol_r) + 1'b1) >= width_r) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 1'b1;
        end else begin
          ocol_nxt = ocol_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WW'(clamp_size(SIZE_RESET, MAX_WIDTH));
      height_r   <= HW'(clamp_size(SIZE_RESET, MAX_HEIGHT));
      col_r      <= '0;
      rowc_r     <= ROW_FIRST;
      ocol_r     <= '0;
      orow_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH)) begin
        width_r <= WW'(clamp_size(32'(cfg_wdata), MAX_WIDTH));
      end
      if (cfg_wr_en && (cfg_index == REG_IMAGE_HEIGHT)) begin
        height_r <= HW'(clamp_size(32'(cfg_wdata), MAX_HEIGHT));
      end
      col_r      <= col_nxt;
      rowc_r     <= rowc_nxt;
      ocol_r     <= ocol_nxt;
      orow_r     <= orow_nxt;
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r      <= (in_data.action == ACT_PIXEL) ? in_data.pixel_in : '0;
      s1_x_r        <= col_r;
      s1_emit_r     <= emit;
      s1_interior_r <= interior;
      s1_last_r     <= last;
      // previous item writes this address at the same edge as our read
      s1_byp_r      <= s1_valid_r && (s1_x_r == col_r);
    end
    if (s1_valid_r) begin
      last_mid_r <= mid;
      last_pix_r <= s1_pix_r;
      cs_a_r     <= cs_b_r;
      cs_b_r     <= newcol;
    end
  end

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_prev (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_x_r),
    .wr_data (s1_pix_r),
    .rd_addr (col_r),
    .rd_data (rd_mid)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_prev2 (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_x_r),
    .wr_data (mid),
    .rd_addr (col_r),
    .rd_data (rd_top)
  );

  assign top    = s1_byp_r ? last_mid_r : rd_top;
  assign mid    = s1_byp_r ? last_pix_r : rd_mid;
  assign newcol = COL_SUM_W'(top) + COL_SUM_W'(mid) + COL_SUM_W'(s1_pix_r);
  assign sum    = SUM_W'(cs_a_r) + SUM_W'(cs_b_r) + SUM_W'(newcol);

  // center of the shifted window is the previous item's middle-row pixel
  assign q_push           = s1_valid_r && s1_emit_r;
  assign q_entry.data     = s1_interior_r ? sum : SUM_W'(last_mid_r);
  assign q_entry.interior = s1_interior_r;
  assign q_entry.last     = s1_last_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < QCW'(Q_DEPTH)))
    else $error("push into a full queue");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit && last) |=> (col_r == '0) && (rowc_r == ROW_FIRST) &&
                              (ocol_r == '0) && (orow_r == '0))
    else $error("counters not cleared after last item of frame");

endmodule

### design/bb3_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified items between front and back end.
// Depends on bb3_pkg.
module bb3_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  bb3_pkg::bb3_entry_t     push_entry,
  input  logic                    pop,
  output logic                    head_valid,
  output bb3_pkg::bb3_entry_t     head,
  output logic [bb3_pkg::QCW-1:0] count
);
  import bb3_pkg::*;

  bb3_entry_t     slots_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];
  assign count      = count_r;

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

### design/bb3_back.sv
`timescale 1ns / 1ps
// Back end: interior divide-by-nine via reciprocal multiply, output register, handshake.
// Depends on bb3_pkg.
module bb3_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  bb3_pkg::bb3_entry_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bb3_pkg::out_item_t   out_data
);
  import bb3_pkg::*;

  logic              out_valid_r;
  out_item_t         out_data_r;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  value;

  assign pop   = head_valid && (!out_valid_r || !out_stall);
  assign prod  = PROD_W'(head.data) * PROD_W'(RECIP_NINE);
  assign value = head.interior ? prod[RECIP_SHIFT +: PIX_W] : head.data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.pixel_out     <= value;
      out_data_r.last_of_frame <= head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
